// ===== hdl/smeu_pkg.sv =====
// Shared types, sizes and codes of the stack machine execute unit.
package smeu_pkg;

  localparam int STACK_DEPTH   = 1024;
  localparam int GLOBAL_COUNT  = 128;
  localparam int CALL_DEPTH    = 128;
  localparam int LIST_COUNT    = 64;
  localparam int LIST_CAPACITY = 16;

  localparam int SP_W  = $clog2(STACK_DEPTH);
  localparam int SC_W  = $clog2(STACK_DEPTH + 1);
  localparam int G_W   = $clog2(GLOBAL_COUNT);
  localparam int C_W   = $clog2(CALL_DEPTH);
  localparam int CL_W  = $clog2(CALL_DEPTH + 1);
  localparam int L_W   = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
  localparam int LM_W  = $clog2(LIST_COUNT + 1);
  localparam int LEN_W = $clog2(LIST_CAPACITY + 1);
  localparam int E_D   = LIST_COUNT * LIST_CAPACITY;
  localparam int E_W   = (E_D > 1) ? $clog2(E_D) : 1;

  localparam logic [4:0] CMD_LIT   = 5'd0;
  localparam logic [4:0] CMD_LOAD  = 5'd1;
  localparam logic [4:0] CMD_STORE = 5'd2;
  localparam logic [4:0] CMD_ADD   = 5'd3;
  localparam logic [4:0] CMD_SUB   = 5'd4;
  localparam logic [4:0] CMD_LESS  = 5'd5;
  localparam logic [4:0] CMD_JZ    = 5'd6;
  localparam logic [4:0] CMD_JMP   = 5'd7;
  localparam logic [4:0] CMD_CALL  = 5'd8;
  localparam logic [4:0] CMD_RET   = 5'd9;
  localparam logic [4:0] CMD_PINT  = 5'd10;
  localparam logic [4:0] CMD_PCHR  = 5'd11;
  localparam logic [4:0] CMD_PSTR  = 5'd12;
  localparam logic [4:0] CMD_PLIST = 5'd13;
  localparam logic [4:0] CMD_NEW   = 5'd14;
  localparam logic [4:0] CMD_LPUSH = 5'd15;
  localparam logic [4:0] CMD_LGET  = 5'd16;
  localparam logic [4:0] CMD_HALT  = 5'd17;

  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_INT   = 3'd1;
  localparam logic [2:0] KIND_CHAR  = 3'd2;
  localparam logic [2:0] KIND_STR   = 3'd3;
  localparam logic [2:0] KIND_ELEM  = 3'd4;
  localparam logic [2:0] KIND_EMPTY = 3'd5;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_HALT     = 4'd1;
  localparam logic [3:0] ST_OVER     = 4'd2;
  localparam logic [3:0] ST_UNDER    = 4'd3;
  localparam logic [3:0] ST_INDEX    = 4'd4;
  localparam logic [3:0] ST_IP       = 4'd5;
  localparam logic [3:0] ST_OPCODE   = 4'd6;
  localparam logic [3:0] ST_LISTFULL = 4'd7;
  localparam logic [3:0] ST_CALLOVER = 4'd8;
  localparam logic [3:0] ST_CALLUNDR = 4'd9;

  typedef enum logic [4:0] {
    OP_LIT, OP_LOAD, OP_STORE, OP_ADD, OP_SUB, OP_LESS, OP_JZ, OP_JMP,
    OP_CALL, OP_RET, OP_PINT, OP_PCHR, OP_PSTR, OP_PLIST, OP_NEW,
    OP_LPUSH, OP_LGET, OP_HALT, OP_BAD
  } op_t;

  typedef struct packed {
    logic [4:0]         cmd;
    logic signed [31:0] arg_one;
    logic [10:0]        arg_two;
    logic [15:0]        jump_target;
  } item_t;

  typedef struct packed {
    logic [15:0]        next_ip;
    logic [2:0]         out_kind;
    logic signed [31:0] out_value;
    logic               last;
    logic [3:0]         status;
  } res_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] arg_one;
    logic [10:0] arg_two;
    logic [15:0] jump_target;
  } dec_t;

endpackage

// ===== hdl/smeu_ram.sv =====
// Generic single write port RAM with one registered read port.
module smeu_ram #(
  parameter int W = 32,
  parameter int D = 1024
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                        wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                        rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/smeu_front.sv =====
// Front end: accepts instruction items, decodes them and queues them.
module smeu_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  smeu_pkg::item_t item,
  output logic           dvalid,
  input  logic           dready,
  output smeu_pkg::dec_t  dec
);
  import smeu_pkg::*;

  dec_t       q [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_in;
  logic       do_out;
  dec_t       d_in;

  always_comb begin
    d_in.arg_one     = item.arg_one;
    d_in.arg_two     = item.arg_two;
    d_in.jump_target = item.jump_target;
    unique case (item.cmd)
      CMD_LIT:   d_in.op = OP_LIT;
      CMD_LOAD:  d_in.op = OP_LOAD;
      CMD_STORE: d_in.op = OP_STORE;
      CMD_ADD:   d_in.op = OP_ADD;
      CMD_SUB:   d_in.op = OP_SUB;
      CMD_LESS:  d_in.op = OP_LESS;
      CMD_JZ:    d_in.op = OP_JZ;
      CMD_JMP:   d_in.op = OP_JMP;
      CMD_CALL:  d_in.op = OP_CALL;
      CMD_RET:   d_in.op = OP_RET;
      CMD_PINT:  d_in.op = OP_PINT;
      CMD_PCHR:  d_in.op = OP_PCHR;
      CMD_PSTR:  d_in.op = OP_PSTR;
      CMD_PLIST: d_in.op = OP_PLIST;
      CMD_NEW:   d_in.op = OP_NEW;
      CMD_LPUSH: d_in.op = OP_LPUSH;
      CMD_LGET:  d_in.op = OP_LGET;
      CMD_HALT:  d_in.op = OP_HALT;
      default:   d_in.op = OP_BAD;
    endcase
  end

  assign full   = (count == 2'd2);
  assign dvalid = (count != 2'd0);
  assign dec    = q[rptr];
  assign do_in  = push && !full;
  assign do_out = dvalid && dready;

  always_ff @(posedge clk) begin
    if (do_in) begin
      q[wptr] <= d_in;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_in) begin
        wptr <= !wptr;
      end
      if (do_out) begin
        rptr <= !rptr;
      end
      count <= count + 2'(do_in) - 2'(do_out);
    end
  end
endmodule

// ===== hdl/smeu_outq.sv =====
// Result queue between the execute engine and the result port.
module smeu_outq (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  smeu_pkg::res_t  wdata,
  output logic           ofull,
  output logic           empty,
  input  logic           pop,
  output smeu_pkg::res_t  result
);
  import smeu_pkg::*;

  res_t       q [4];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;
  logic       do_in;
  logic       do_out;

  assign ofull  = (count == 3'd4);
  assign empty  = (count == 3'd0);
  assign result = q[rptr];
  assign do_in  = wr && !ofull;
  assign do_out = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_in) begin
      q[wptr] <= wdata;
    end
    if (rst) begin
      wptr  <= 2'd0;
      rptr  <= 2'd0;
      count <= 3'd0;
    end else begin
      if (do_in) begin
        wptr <= wptr + 2'd1;
      end
      if (do_out) begin
        rptr <= rptr + 2'd1;
      end
      count <= count + 3'(do_in) - 3'(do_out);
    end
  end
endmodule

// ===== hdl/smeu_back.sv =====
// Execute engine: machine state, memories and the instruction sequencer.
module smeu_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_data,
  input  logic           dvalid,
  output logic           dready,
  input  smeu_pkg::dec_t  dec,
  input  logic           ofull,
  output logic           opush,
  output smeu_pkg::res_t  odata
);
  import smeu_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_R1, S_R2, S_X, S_EL, S_PL, S_EMIT} state_t;

  state_t             state;
  logic [15:0]        plen;
  logic [15:0]        ip;
  logic [3:0]         stopped;
  logic [SC_W-1:0]    sc;
  logic [SP_W-1:0]    fb;
  logic [CL_W-1:0]    cl;
  logic [LM_W-1:0]    lm;
  logic [GLOBAL_COUNT-1:0] gvalid;
  dec_t               ins;
  logic [G_W-1:0]     gidx;
  logic [31:0]        ra;
  logic [31:0]        rb;
  logic [15:0]        rret;
  logic [SP_W-1:0]    rfrm;
  logic [L_W-1:0]     rid;
  logic [LEN_W-1:0]   k;
  res_t               res;

  logic               stk_we;
  logic [SP_W-1:0]    stk_wa;
  logic [31:0]        stk_wd;
  logic [SP_W-1:0]    stk_ra;
  logic [31:0]        stk_rd;
  logic               glb_we;
  logic [31:0]        glb_rd;
  logic               call_we;
  logic [C_W-1:0]     call_ra;
  logic [15:0]        ret_rd;
  logic [SP_W-1:0]    frm_rd;
  logic               len_we;
  logic [L_W-1:0]     len_wa;
  logic [LEN_W-1:0]   len_wd;
  logic [L_W-1:0]     len_ra;
  logic [LEN_W-1:0]   len_rd;
  logic               el_we;
  logic [E_W-1:0]     el_wa;
  logic [E_W-1:0]     el_ra;
  logic [31:0]        el_rd;

  logic [3:0]         pre_code;
  logic [3:0]         x_code;
  logic [2:0]         x_kind;
  logic [31:0]        x_value;
  logic               room;
  logic               gbad;
  logic               bad_a;
  logic               bad_b;
  logic [15:0]        nip;
  logic [15:0]        nip_x;
  logic [SP_W-1:0]    loc_x;
  logic [SP_W-1:0]    loc_d;
  logic [E_W-1:0]     el_base;
  logic               pl_last;
  logic [31:0]        arith;

  assign room    = sc < SC_W'(STACK_DEPTH);
  assign gbad    = dec.arg_one[31] || (dec.arg_one >= 32'(GLOBAL_COUNT));
  assign bad_a   = ra[31] || (ra >= 32'(lm));
  assign bad_b   = rb[31] || (rb >= 32'(lm));
  assign nip     = ip + 16'd1;
  assign loc_d   = SP_W'(fb + dec.arg_one[SP_W-1:0]);
  assign loc_x   = SP_W'(fb + ins.arg_one[SP_W-1:0]);
  assign el_base = E_W'(int'(rid) * LIST_CAPACITY);
  assign pl_last = (LEN_W'(k + 1'b1) == len_rd);
  assign dready  = (state == S_IDLE);

  always_comb begin
    pre_code = ST_OK;
    if (stopped != ST_OK) begin
      pre_code = stopped;
    end else if (ip >= plen) begin
      pre_code = ST_IP;
    end else begin
      unique case (dec.op)
        OP_LIT: if (!room) pre_code = ST_OVER;
        OP_LOAD: begin
          if (dec.arg_two == 11'd0 && gbad) pre_code = ST_INDEX;
          else if (!room) pre_code = ST_OVER;
        end
        OP_STORE: begin
          if (sc == SC_W'(0)) pre_code = ST_UNDER;
          else if (dec.arg_two == 11'd0 && gbad) pre_code = ST_INDEX;
        end
        OP_ADD, OP_SUB, OP_LESS, OP_LPUSH, OP_LGET: begin
          if (sc < SC_W'(2)) pre_code = ST_UNDER;
        end
        OP_JZ, OP_PINT, OP_PCHR, OP_PSTR, OP_PLIST: begin
          if (sc == SC_W'(0)) pre_code = ST_UNDER;
        end
        OP_JMP: pre_code = ST_OK;
        OP_CALL: if (cl >= CL_W'(CALL_DEPTH)) pre_code = ST_CALLOVER;
        OP_RET: begin
          if (sc == SC_W'(0)) pre_code = ST_UNDER;
          else if (cl == CL_W'(0)) pre_code = ST_CALLUNDR;
        end
        OP_NEW: begin
          if (lm >= LM_W'(LIST_COUNT)) pre_code = ST_LISTFULL;
          else if (!room) pre_code = ST_OVER;
        end
        OP_HALT: pre_code = ST_HALT;
        OP_BAD:  pre_code = ST_OPCODE;
        default: pre_code = ST_OPCODE;
      endcase
    end
  end

  always_comb begin
    x_code = ST_OK;
    nip_x  = nip;
    unique case (ins.op)
      OP_PLIST: if (bad_a) x_code = ST_INDEX;
      OP_LPUSH: begin
        if (bad_b) x_code = ST_INDEX;
        else if (len_rd >= LEN_W'(LIST_CAPACITY)) x_code = ST_LISTFULL;
      end
      OP_LGET: begin
        if (bad_b) x_code = ST_INDEX;
        else if (ra[31] || ra >= 32'(len_rd)) x_code = ST_INDEX;
      end
      OP_JZ:   if (ra == 32'd0) nip_x = ins.jump_target;
      OP_JMP:  nip_x = ins.jump_target;
      OP_CALL: nip_x = ins.arg_one[15:0];
      OP_RET:  nip_x = rret;
      default: x_code = ST_OK;
    endcase
  end

  always_comb begin
    x_kind  = KIND_NONE;
    x_value = 32'd0;
    unique case (ins.op)
      OP_PINT: begin
        x_kind  = KIND_INT;
        x_value = ra;
      end
      OP_PSTR: begin
        x_kind  = KIND_STR;
        x_value = ra;
      end
      OP_PCHR: begin
        x_kind  = KIND_CHAR;
        x_value = {24'd0, ra[7:0]};
      end
      OP_PLIST: if (len_rd == LEN_W'(0)) x_kind = KIND_EMPTY;
      default: x_kind = KIND_NONE;
    endcase
  end

  always_comb begin
    unique case (ins.op)
      OP_ADD:  arith = rb + ra;
      OP_SUB:  arith = rb - ra;
      default: arith = {31'd0, ($signed(rb) < $signed(ra))};
    endcase
  end

  always_comb begin
    stk_we  = 1'b0;
    stk_wa  = SP_W'(sc);
    stk_wd  = ra;
    stk_ra  = SP_W'(sc - SC_W'(1));
    glb_we  = 1'b0;
    call_we = 1'b0;
    call_ra = C_W'(cl - CL_W'(1));
    len_we  = 1'b0;
    len_wa  = rid;
    len_wd  = LEN_W'(len_rd + 1'b1);
    len_ra  = rid;
    el_we   = 1'b0;
    el_wa   = E_W'(el_base + E_W'(len_rd));
    el_ra   = E_W'(el_base + E_W'(k));
    unique case (state)
      S_IDLE: begin
        if (dec.op == OP_LOAD && dec.arg_two != 11'd0) stk_ra = loc_d;
      end
      S_R1: stk_ra = SP_W'(sc - SC_W'(2));
      S_R2: len_ra = (ins.op == OP_PLIST) ? ra[L_W-1:0] : stk_rd[L_W-1:0];
      S_X: begin
        el_ra = el_base;
        unique case (ins.op)
          OP_LIT: begin
            stk_we = 1'b1;
            stk_wd = ins.arg_one;
          end
          OP_LOAD: stk_we = 1'b1;
          OP_STORE: begin
            glb_we = (ins.arg_two == 11'd0);
            stk_we = (ins.arg_two != 11'd0);
            stk_wa = loc_x;
          end
          OP_ADD, OP_SUB, OP_LESS: begin
            stk_we = 1'b1;
            stk_wa = SP_W'(sc - SC_W'(2));
            stk_wd = arith;
          end
          OP_CALL: call_we = 1'b1;
          OP_RET: begin
            stk_we = 1'b1;
            stk_wa = fb;
          end
          OP_NEW: begin
            stk_we = 1'b1;
            stk_wd = 32'(lm);
            len_we = 1'b1;
            len_wa = L_W'(lm);
            len_wd = LEN_W'(0);
          end
          OP_LPUSH: begin
            el_we  = (x_code == ST_OK);
            len_we = (x_code == ST_OK);
          end
          OP_LGET: el_ra = E_W'(el_base + E_W'(ra[LEN_W-1:0]));
          default: stk_we = 1'b0;
        endcase
      end
      S_EL: begin
        stk_we = 1'b1;
        stk_wa = SP_W'(sc - SC_W'(2));
        stk_wd = el_rd;
      end
      S_PL: begin
        if (!ofull) el_ra = E_W'(el_base + E_W'(LEN_W'(k + 1'b1)));
      end
      default: stk_we = 1'b0;
    endcase
  end

  assign opush = ((state == S_EMIT) || (state == S_PL)) && !ofull;
  always_comb begin
    odata = res;
    if (state == S_PL) begin
      odata.next_ip   = ip;
      odata.out_kind  = KIND_ELEM;
      odata.out_value = el_rd;
      odata.last      = pl_last;
      odata.status    = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      plen    <= 16'd0;
      ip      <= 16'd0;
      stopped <= ST_OK;
      sc      <= '0;
      fb      <= '0;
      cl      <= '0;
      lm      <= '0;
      gvalid  <= '0;
    end else begin
      if (cfg_we) begin
        plen <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (dvalid) begin
            ins  <= dec;
            gidx <= dec.arg_one[G_W-1:0];
            if (pre_code != ST_OK) begin
              stopped <= pre_code;
              res     <= '{ip, KIND_NONE, 32'sd0, 1'b1, pre_code};
              state   <= S_EMIT;
            end else begin
              state <= S_R1;
            end
          end
        end
        S_R1: begin
          if (ins.op == OP_LOAD && ins.arg_two == 11'd0) begin
            ra <= gvalid[gidx] ? glb_rd : 32'd0;
          end else begin
            ra <= stk_rd;
          end
          rret  <= ret_rd;
          rfrm  <= frm_rd;
          state <= S_R2;
        end
        S_R2: begin
          rb    <= stk_rd;
          rid   <= len_ra;
          state <= S_X;
        end
        S_X: begin
          if (x_code != ST_OK) begin
            stopped <= x_code;
            res     <= '{ip, KIND_NONE, 32'sd0, 1'b1, x_code};
            state   <= S_EMIT;
          end else begin
            res <= '{nip_x, x_kind, x_value, 1'b1, ST_OK};
            if (ins.op == OP_LGET) begin
              state <= S_EL;
            end else begin
              ip <= nip_x;
              if (ins.op == OP_PLIST && len_rd != LEN_W'(0)) state <= S_PL;
              else state <= S_EMIT;
            end
            unique case (ins.op)
              OP_LIT, OP_LOAD: sc <= sc + SC_W'(1);
              OP_STORE, OP_ADD, OP_SUB, OP_LESS, OP_JZ, OP_LPUSH: begin
                sc <= sc - SC_W'(1);
                if (ins.op == OP_STORE && ins.arg_two == 11'd0) gvalid[gidx] <= 1'b1;
              end
              OP_CALL: begin
                cl <= cl + CL_W'(1);
                fb <= SP_W'(sc - SC_W'(ins.arg_two));
              end
              OP_RET: begin
                cl <= cl - CL_W'(1);
                sc <= SC_W'(fb) + SC_W'(1);
                fb <= rfrm;
              end
              OP_PINT, OP_PSTR, OP_PCHR: sc <= sc - SC_W'(1);
              OP_PLIST: begin
                sc <= sc - SC_W'(1);
                k  <= '0;
              end
              OP_NEW: begin
                sc <= sc + SC_W'(1);
                lm <= lm + LM_W'(1);
              end
              default: sc <= sc;
            endcase
          end
        end
        S_EL: begin
          sc    <= sc - SC_W'(1);
          ip    <= nip;
          res   <= '{nip, KIND_NONE, 32'sd0, 1'b1, ST_OK};
          state <= S_EMIT;
        end
        S_PL: begin
          if (!ofull) begin
            k <= LEN_W'(k + 1'b1);
            if (pl_last) state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (!ofull) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  smeu_ram #(.W(32), .D(STACK_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd)
  );
  smeu_ram #(.W(32), .D(GLOBAL_COUNT)) u_glob (
    .clk(clk), .we(glb_we), .waddr(gidx), .wdata(ra),
    .raddr(dec.arg_one[G_W-1:0]), .rdata(glb_rd)
  );
  smeu_ram #(.W(16), .D(CALL_DEPTH)) u_ret (
    .clk(clk), .we(call_we), .waddr(C_W'(cl)), .wdata(nip), .raddr(call_ra), .rdata(ret_rd)
  );
  smeu_ram #(.W(SP_W), .D(CALL_DEPTH)) u_frm (
    .clk(clk), .we(call_we), .waddr(C_W'(cl)), .wdata(fb), .raddr(call_ra), .rdata(frm_rd)
  );
  smeu_ram #(.W(LEN_W), .D(LIST_COUNT)) u_len (
    .clk(clk), .we(len_we), .waddr(len_wa), .wdata(len_wd), .raddr(len_ra), .rdata(len_rd)
  );
  smeu_ram #(.W(32), .D(E_D)) u_elem (
    .clk(clk), .we(el_we), .waddr(el_wa), .wdata(ra), .raddr(el_ra), .rdata(el_rd)
  );
endmodule

// ===== hdl/stack_machine_execute_unit_top.sv =====
// Top level of the stack machine execute unit.
// Instruction items enter through push/full and are accepted when push is
// high and full is low. Results leave through empty/pop: the oldest result
// sits on the result port while empty is low and is taken when pop is high.
// The program length register is written through cfg_we and cfg_data; the user
// must do so only while the unit is idle, as the block does not enforce it.
// Each instruction runs through a decode queue of two items and then the
// execute sequencer, which reads the operand stack memory one entry a cycle.
// A plain instruction runs from the queue head through S_IDLE, S_R1, S_R2 and
// S_X to S_EMIT, which gives its result; list get adds S_EL before S_EMIT, an
// error found at decode goes from S_IDLE straight to S_EMIT, and a list print
// gives one element a cycle in S_PL while the result queue is not full. The
// sequencer takes the next instruction only in the cycle after the last result.
// An instruction is accepted into the decode queue while earlier ones run.
// Reset empties both queues and clears the stack count, frame, call level,
// list count, instruction pointer, status and global variables at once.
// When the receiver stalls, the four-entry result queue fills, the sequencer
// waits, and then the decode queue fills and raises full.
module stack_machine_execute_unit_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  smeu_pkg::item_t item,
  input  logic           pop,
  output logic           empty,
  output smeu_pkg::res_t  result,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_data
);
  import smeu_pkg::*;

  logic dvalid;
  logic dready;
  dec_t dec;
  logic ofull;
  logic opush;
  res_t odata;

  smeu_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .dvalid(dvalid), .dready(dready), .dec(dec)
  );

  smeu_back u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .dvalid(dvalid), .dready(dready), .dec(dec),
    .ofull(ofull), .opush(opush), .odata(odata)
  );

  smeu_outq u_outq (
    .clk(clk), .rst(rst), .wr(opush), .wdata(odata), .ofull(ofull),
    .empty(empty), .pop(pop), .result(result)
  );
endmodule

// ===== hdl/smeu_checker.sv =====
// Port-level checks of the execute unit and their binding to the top level.
module smeu_checker (
  input logic           clk,
  input logic           rst,
  input logic           full,
  input logic           empty,
  input smeu_pkg::res_t  result
);
  import smeu_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("Queues not empty after reset.");

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status != ST_OK) |-> (result.last && result.out_kind == KIND_NONE))
    else $error("Error result is not a single plain item.");

  a_empty_list: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.out_kind == KIND_EMPTY) |-> (result.last && result.out_value == 0))
    else $error("Empty list marker malformed.");

  a_elem_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.out_kind == KIND_ELEM) |-> (result.status == ST_OK))
    else $error("List element carries an error status.");
endmodule

bind stack_machine_execute_unit_top smeu_checker u_smeu_checker (.*);

// ===== dv/stack_machine_execute_unit_top_test.sv =====
// Self-checking testbench of the stack machine execute unit: instruction programs in, results checked.
`timescale 1ns / 1ps
module stack_machine_execute_unit_top_test;
  import smeu_pkg::*;

  class exec_scoreboard;
    logic [31:0] stk[STACK_DEPTH];
    int unsigned depth;
    int unsigned frame;
    logic [31:0] globals[GLOBAL_COUNT];
    logic [15:0] ret_ip[CALL_DEPTH];
    int unsigned saved_frame[CALL_DEPTH];
    int unsigned level;
    int unsigned list_len[LIST_COUNT];
    logic [31:0] elems[E_D];
    int unsigned lists_made;
    logic [15:0] ip;
    logic [3:0]  stop_code;
    logic [15:0] prog_len;
    res_t        waiting[$];
    int          errors;

    function new();
      depth = 0;
      frame = 0;
      level = 0;
      lists_made = 0;
      ip = 0;
      stop_code = ST_OK;
      prog_len = 0;
      errors = 0;
      foreach (globals[i]) globals[i] = 0;
    endfunction

    function void set_length(logic [15:0] v);
      prog_len = v;
    endfunction

    function void add(logic [15:0] nip, logic [2:0] kind, logic [31:0] val, logic lst,
                      logic [3:0] st);
      res_t r;
      r.next_ip = nip;
      r.out_kind = kind;
      r.out_value = val;
      r.last = lst;
      r.status = st;
      waiting.push_back(r);
    endfunction

    function void stop(logic [3:0] code);
      stop_code = code;
      add(ip, KIND_NONE, 0, 1'b1, code);
    endfunction

    function void push_val(logic [31:0] v);
      stk[depth] = v;
      depth++;
    endfunction

    function logic [31:0] pop_val();
      depth--;
      return stk[depth];
    endfunction

    function int unsigned local_slot(logic signed [31:0] off);
      longint a;
      a = (longint'(frame) + longint'(off)) % STACK_DEPTH;
      if (a < 0) a += STACK_DEPTH;
      return int'(a);
    endfunction

    function void note(item_t it);
      logic [15:0] nip;
      logic [31:0] x, y;
      logic [2:0]  kind;
      int unsigned id, n;
      bit          room;
      nip = ip + 16'd1;
      room = depth < STACK_DEPTH;
      if (stop_code != ST_OK) begin
        add(ip, KIND_NONE, 0, 1'b1, stop_code);
        return;
      end
      if (ip >= prog_len) begin
        stop(ST_IP);
        return;
      end
      case (it.cmd)
        CMD_LIT: begin
          if (!room) begin stop(ST_OVER); return; end
          push_val(it.arg_one);
        end
        CMD_LOAD: begin
          if (it.arg_two == 0) begin
            if (it.arg_one < 0 || it.arg_one >= GLOBAL_COUNT) begin stop(ST_INDEX); return; end
            if (!room) begin stop(ST_OVER); return; end
            push_val(globals[it.arg_one]);
          end else begin
            if (!room) begin stop(ST_OVER); return; end
            push_val(stk[local_slot(it.arg_one)]);
          end
        end
        CMD_STORE: begin
          if (depth < 1) begin stop(ST_UNDER); return; end
          if (it.arg_two == 0) begin
            if (it.arg_one < 0 || it.arg_one >= GLOBAL_COUNT) begin stop(ST_INDEX); return; end
            globals[it.arg_one] = pop_val();
          end else begin
            x = pop_val();
            stk[local_slot(it.arg_one)] = x;
          end
        end
        CMD_ADD, CMD_SUB, CMD_LESS: begin
          if (depth < 2) begin stop(ST_UNDER); return; end
          y = pop_val();
          x = pop_val();
          if (it.cmd == CMD_ADD) push_val(x + y);
          else if (it.cmd == CMD_SUB) push_val(x - y);
          else push_val(($signed(x) < $signed(y)) ? 32'd1 : 32'd0);
        end
        CMD_JZ: begin
          if (depth < 1) begin stop(ST_UNDER); return; end
          x = pop_val();
          if (x == 0) nip = it.jump_target;
        end
        CMD_JMP: nip = it.jump_target;
        CMD_CALL: begin
          if (level >= CALL_DEPTH) begin stop(ST_CALLOVER); return; end
          ret_ip[level] = nip;
          saved_frame[level] = frame;
          level++;
          frame = (depth + STACK_DEPTH - (it.arg_two % STACK_DEPTH)) % STACK_DEPTH;
          nip = it.arg_one[15:0];
        end
        CMD_RET: begin
          if (depth < 1) begin stop(ST_UNDER); return; end
          if (level == 0) begin stop(ST_CALLUNDR); return; end
          x = pop_val();
          depth = frame;
          level--;
          nip = ret_ip[level];
          frame = saved_frame[level];
          push_val(x);
        end
        CMD_PINT, CMD_PCHR, CMD_PSTR: begin
          if (depth < 1) begin stop(ST_UNDER); return; end
          x = pop_val();
          if (it.cmd == CMD_PCHR) begin
            x = x & 32'hFF;
            kind = KIND_CHAR;
          end else begin
            kind = (it.cmd == CMD_PINT) ? KIND_INT : KIND_STR;
          end
          ip = nip;
          add(nip, kind, x, 1'b1, ST_OK);
          return;
        end
        CMD_PLIST: begin
          if (depth < 1) begin stop(ST_UNDER); return; end
          x = stk[depth - 1];
          if ($signed(x) < 0 || $signed(x) >= int'(lists_made)) begin stop(ST_INDEX); return; end
          depth--;
          id = x;
          n = list_len[id];
          ip = nip;
          if (n == 0) begin
            add(nip, KIND_EMPTY, 0, 1'b1, ST_OK);
            return;
          end
          for (int k = 0; k < n; k++)
            add(nip, KIND_ELEM, elems[id * LIST_CAPACITY + k], k + 1 == n, ST_OK);
          return;
        end
        CMD_NEW: begin
          if (lists_made >= LIST_COUNT) begin stop(ST_LISTFULL); return; end
          if (!room) begin stop(ST_OVER); return; end
          list_len[lists_made] = 0;
          push_val(lists_made);
          lists_made++;
        end
        CMD_LPUSH: begin
          if (depth < 2) begin stop(ST_UNDER); return; end
          x = stk[depth - 1];
          y = stk[depth - 2];
          if ($signed(y) < 0 || $signed(y) >= int'(lists_made)) begin stop(ST_INDEX); return; end
          id = y;
          if (list_len[id] >= LIST_CAPACITY) begin stop(ST_LISTFULL); return; end
          elems[id * LIST_CAPACITY + list_len[id]] = x;
          list_len[id]++;
          depth--;
        end
        CMD_LGET: begin
          if (depth < 2) begin stop(ST_UNDER); return; end
          x = stk[depth - 1];
          y = stk[depth - 2];
          if ($signed(y) < 0 || $signed(y) >= int'(lists_made)) begin stop(ST_INDEX); return; end
          id = y;
          if ($signed(x) < 0 || $signed(x) >= int'(list_len[id])) begin stop(ST_INDEX); return; end
          depth -= 2;
          push_val(elems[id * LIST_CAPACITY + x]);
        end
        CMD_HALT: begin
          stop(ST_HALT);
          return;
        end
        default: begin
          stop(ST_OPCODE);
          return;
        end
      endcase
      ip = nip;
      add(nip, KIND_NONE, 0, 1'b1, ST_OK);
    endfunction

    function void check(res_t got);
      res_t exp_r;
      if (waiting.size() == 0) begin
        $error("unexpected result: next_ip %0d kind %0d value %0d", got.next_ip,
               got.out_kind, got.out_value);
        errors++;
        return;
      end
      exp_r = waiting.pop_front();
      if (got.next_ip !== exp_r.next_ip) begin
        $error("next_ip: expected %0d, actual %0d", exp_r.next_ip, got.next_ip);
        errors++;
      end
      if (got.out_kind !== exp_r.out_kind) begin
        $error("out_kind: expected %0d, actual %0d", exp_r.out_kind, got.out_kind);
        errors++;
      end
      if (got.out_value !== exp_r.out_value) begin
        $error("out_value: expected %0d, actual %0d", exp_r.out_value, got.out_value);
        errors++;
      end
      if (got.last !== exp_r.last) begin
        $error("last: expected %0d, actual %0d", exp_r.last, got.last);
        errors++;
      end
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, actual %0d", exp_r.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic   clk;
  logic   rst;
  logic   push;
  logic   full;
  item_t  item;
  logic   pop;
  logic   empty;
  res_t   result;
  logic   cfg_we;
  logic   [15:0] cfg_data;

  exec_scoreboard sb;
  item_t          program_q[$];
  bit             tx_quiet;
  bit             rx_quiet;

  stack_machine_execute_unit_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item), .pop(pop),
    .empty(empty), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function logic [15:0] pick_target();
    return (sb.prog_len > 1000) ? 16'($urandom_range(0, sb.prog_len - 1000)) : 16'd0;
  endfunction

  function void plan(logic [4:0] cmd, int a1, int a2, int tgt);
    item_t it;
    it.cmd = cmd;
    it.arg_one = a1;
    it.arg_two = 11'(a2);
    it.jump_target = 16'(tgt);
    program_q.push_back(it);
  endfunction

  // Unused fields carry random bits so every input bit toggles.
  function void plan_op(logic [4:0] cmd, int a1);
    plan(cmd, a1, $urandom_range(0, 1024), $urandom);
  endfunction

  function void plan_routine();
    int unsigned id, n, m, w, start;
    logic [4:0]  ops[3];
    ops[0] = CMD_ADD;
    ops[1] = CMD_SUB;
    ops[2] = CMD_LESS;
    if (sb.depth > 24) begin
      repeat ($urandom_range(4, 10))
        plan(CMD_STORE, $urandom_range(0, GLOBAL_COUNT - 1), 0, $urandom);
      return;
    end
    case ($urandom_range(0, 9))
      0: begin
        plan_op(CMD_LIT, pick_value());
        plan_op(CMD_LIT, pick_value());
        plan_op(ops[$urandom_range(0, 2)], $urandom);
        case ($urandom_range(0, 3))
          0: plan_op(CMD_PINT, $urandom);
          1: plan_op(CMD_PCHR, $urandom);
          2: plan_op(CMD_PSTR, $urandom);
          default: plan(CMD_STORE, $urandom_range(0, GLOBAL_COUNT - 1), 0, $urandom);
        endcase
      end
      1: begin
        w = $urandom_range(0, GLOBAL_COUNT - 1);
        plan_op(CMD_LIT, pick_value());
        plan(CMD_STORE, w, 0, $urandom);
        plan(CMD_LOAD, $urandom_range(0, 1) ? w : $urandom_range(0, GLOBAL_COUNT - 1), 0,
             $urandom);
        plan_op(CMD_PINT, $urandom);
      end
      2: begin
        if (sb.depth == 0) plan_op(CMD_LIT, pick_value());
        else begin
          w = $urandom_range(0, sb.depth - 1);
          plan(CMD_LOAD, (w - sb.frame) + 1024 * ($urandom_range(0, 4194303) - 2097152),
               $urandom_range(1, 1024), $urandom);
          plan_op(CMD_PINT, $urandom);
        end
      end
      3: begin
        plan_op(CMD_LIT, pick_value());
        plan(CMD_STORE, $urandom, $urandom_range(1, 1024), $urandom);
      end
      4: begin
        if ($urandom_range(0, 1)) plan(CMD_JMP, $urandom, $urandom_range(0, 1024), pick_target());
        else begin
          plan_op(CMD_LIT, $urandom_range(0, 1) ? 32'd0 : pick_value());
          plan(CMD_JZ, $urandom, $urandom_range(0, 1024), pick_target());
        end
      end
      5: begin
        if (sb.level > 100) begin
          plan_op(CMD_LIT, pick_value());
          plan_op(CMD_RET, $urandom);
        end else begin
          n = $urandom_range(0, 3);
          repeat (n) plan_op(CMD_LIT, pick_value());
          plan(CMD_CALL, {16'($urandom_range(0, 65535)), pick_target()},
               (n == 0 && $urandom_range(0, 1)) ? 11'd1024 : n, $urandom);
          if ($urandom_range(0, 3) != 0) begin
            if (n > 0) plan(CMD_LOAD, $urandom_range(0, n - 1), $urandom_range(1, 1024), $urandom);
            else plan_op(CMD_LIT, pick_value());
            plan_op(CMD_RET, $urandom);
          end
        end
      end
      6, 7: begin
        m = 0;
        if (sb.lists_made < LIST_COUNT && $urandom_range(0, 1)) begin
          plan_op(CMD_NEW, $urandom);
          m = LIST_CAPACITY;
        end else if (sb.lists_made > 0) begin
          start = $urandom_range(0, sb.lists_made - 1);
          for (int k = 0; k < sb.lists_made; k++) begin
            id = (start + k) % sb.lists_made;
            if (m == 0 && sb.list_len[id] < LIST_CAPACITY) begin
              plan_op(CMD_LIT, id);
              m = LIST_CAPACITY - sb.list_len[id];
            end
          end
        end
        if (m != 0) begin
          repeat ($urandom_range(0, 3) == 0 ? m : $urandom_range(0, m)) begin
            plan_op(CMD_LIT, pick_value());
            plan_op(CMD_LPUSH, $urandom);
          end
          if ($urandom_range(0, 2) != 0) plan_op(CMD_PLIST, $urandom);
          else plan(CMD_STORE, $urandom_range(0, GLOBAL_COUNT - 1), 0, $urandom);
        end
      end
      8: begin
        if (sb.lists_made > 0) begin
          id = $urandom_range(0, sb.lists_made - 1);
          if (sb.list_len[id] > 0) begin
            plan_op(CMD_LIT, id);
            plan_op(CMD_LIT, $urandom_range(0, sb.list_len[id] - 1));
            plan_op(CMD_LGET, $urandom);
            plan_op(CMD_PINT, $urandom);
          end
        end
      end
      default: begin
        if (sb.lists_made > 0 && sb.depth > 0) plan_op(CMD_PLIST, $urandom);
        if (sb.depth > 0) plan(CMD_STORE, $urandom_range(0, GLOBAL_COUNT - 1), 0, $urandom);
      end
    endcase
  endfunction

  task automatic send_instruction(item_t it);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    sb.note(it);
  endtask

  task automatic run_program(int count);
    int sent;
    sent = 0;
    while (sent < count || program_q.size() != 0) begin
      if (program_q.size() == 0) plan_routine();
      if (program_q.size() != 0) begin
        send_instruction(program_q.pop_front());
        sent++;
      end
    end
    push <= 1'b0;
  endtask

  task automatic drain_results();
    while (sb.waiting.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_length(logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_length(v);
  endtask

  initial begin
    int unsigned kind;
    item_t it;
    sb = new();
    clk = 0;
    rst = 1;
    push = 0;
    item = '0;
    pop = 0;
    cfg_we = 0;
    cfg_data = 0;
    tx_quiet = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_length(16'hFFFF);

    plan_op(CMD_LIT, 32'h7FFF_FFFF);
    plan_op(CMD_LIT, 32'h1);
    plan_op(CMD_ADD, $urandom);
    plan_op(CMD_PINT, $urandom);
    plan_op(CMD_LIT, 32'h8000_0000);
    plan_op(CMD_LIT, 32'h1);
    plan_op(CMD_SUB, $urandom);
    plan_op(CMD_PINT, $urandom);
    plan_op(CMD_LIT, 32'hFFFF_FFFF);
    plan_op(CMD_LIT, 32'h0);
    plan_op(CMD_LESS, $urandom);
    plan_op(CMD_PINT, $urandom);
    plan_op(CMD_LIT, 32'h1234_56A7);
    plan_op(CMD_PCHR, $urandom);
    plan_op(CMD_LIT, 32'd42);
    plan_op(CMD_PSTR, $urandom);
    plan_op(CMD_NEW, $urandom);
    plan_op(CMD_PLIST, $urandom);
    plan(CMD_JMP, $urandom, 0, 16'd0);
    plan_op(CMD_LIT, 32'd0);
    plan(CMD_JZ, $urandom, 0, 16'd64000);
    plan_op(CMD_LIT, 32'd5);
    plan(CMD_CALL, 32'h8000_0005, 11'd1024, $urandom);
    plan_op(CMD_RET, $urandom);
    run_program(0);

    for (int phase = 0; phase < 4; phase++) begin
      drain_results();
      write_length(16'($urandom_range((int'(sb.ip) > 64535) ? 65535 : int'(sb.ip) + 1000,
                                      65535)));
      run_program(115);
    end

    drain_results();
    kind = $urandom_range(0, 3);
    plan_op(CMD_LIT, pick_value());
    if (kind == 0) write_length(16'd0);
    else if (kind == 1) program_q[0].cmd = CMD_HALT;
    else if (kind == 2) program_q[0].cmd = 5'($urandom_range(18, 31));
    else begin
      program_q[0].cmd = CMD_LOAD;
      program_q[0].arg_two = 0;
      program_q[0].arg_one = $urandom_range(0, 1) ? (32'h8000_0000 | $urandom)
                                                   : $urandom_range(GLOBAL_COUNT, 100000);
    end
    repeat (4) begin
      it = '{cmd: 5'($urandom_range(0, 31)), arg_one: $urandom,
             arg_two: 11'($urandom_range(0, 1024)), jump_target: 16'($urandom)};
      program_q.push_back(it);
    end
    run_program(0);

    while (sb.waiting.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side, with one long hold-off to back the unit up into full.
  initial begin
    int gap;
    int taken;
    taken = 0;
    rx_quiet = 0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
      gap = rx_quiet ? 0 : $urandom_range(0, 11);
      if (taken == 60) gap = 400;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      sb.check(result);
      taken++;
    end
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
